// ===== rtl/srg_pkg.sv =====
// ----------------------------------------------------------------------------
// srg_pkg
// Shared constants, types and helpers of the subtractive random generator.
// ----------------------------------------------------------------------------
package srg_pkg;

  localparam int WordBits      = 31;
  localparam int TableWords    = 55;
  localparam int ShortLag      = 24;
  localparam int LongLag       = TableWords - ShortLag;
  localparam int SeedStride    = 21;
  localparam int RefreshPasses = 5;
  localparam int IdxBits       = $clog2(TableWords);
  localparam int CntBits       = $clog2(WordBits);

  localparam logic [WordBits-1:0] SeedReset = 31'd2147169489;

  localparam logic OP_RESEED = 1'b0;

  typedef logic [WordBits-1:0] word_t;
  typedef logic [IdxBits-1:0]  idx_t;

  typedef struct packed {
    logic seed_start;
    logic seed_step;
    logic ref_start;
    logic ref_read;
    logic ref_write;
    logic word_read;
    logic word_load_mem;
    logic word_load_ref;
    logic div_step;
    logic load_in;
    logic out_load;
    logic out_zero;
  } cmd_t;

  typedef struct packed {
    logic seed_last;
    logic ref_last;
    logic pos_zero;
    logic div_last;
    logic reject;
    logic out_free;
    logic in_reseed;
    logic in_small;
  } stat_t;

  function automatic word_t sub31(input word_t a, input word_t b);
    return a - b;
  endfunction

endpackage

// ===== rtl/srg_if.sv =====
// ----------------------------------------------------------------------------
// srg channel interfaces
// Valid/ready channels for the request, result and seed write words.
// ----------------------------------------------------------------------------
interface srg_in_if import srg_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  opcode;
  word_t modulus;

  modport source (output valid, output opcode, output modulus, input ready);
  modport sink   (input valid, input opcode, input modulus, output ready);
endinterface

interface srg_out_if import srg_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface srg_cfg_if import srg_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t seed_value;

  modport source (output valid, output seed_value, input ready);
  modport sink   (input valid, input seed_value, output ready);
endinterface

// ===== rtl/srg_dp.sv =====
// ----------------------------------------------------------------------------
// srg_dp
// Datapath: lag table memory, seed fill registers, refresh indexing,
// bit-serial remainder unit, rejection test and output register.
// ----------------------------------------------------------------------------
module srg_dp import srg_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  cmd_t            cmd,
  output stat_t           st,
  input  logic            in_opcode,
  input  word_t           in_modulus,
  srg_cfg_if.sink         cfg_bus,
  srg_out_if.source       out_bus
);

  word_t mem [TableWords];

  word_t seed_r;
  word_t rot_r;
  word_t prev_r;
  word_t next_r;
  idx_t  k_r;
  idx_t  i_r;
  idx_t  pos_r;
  word_t m_r;
  word_t r_r;
  word_t d_r;
  word_t rem_r;
  logic [CntBits-1:0] cnt_r;
  word_t rd_a_r;
  word_t rd_b_r;
  logic  out_valid_r;
  word_t out_value_r;

  logic [IdxBits:0]  k_sum;
  idx_t              k_nxt;
  idx_t              j_idx;
  idx_t              ra_a;
  word_t             ref_val;
  word_t             rot_nxt;
  word_t             next_nxt;
  logic              mem_we;
  idx_t              mem_wa;
  word_t             mem_wd;
  logic [WordBits:0] trial;
  logic              trial_ge;
  logic [WordBits:0] trial_sub;
  word_t             rem_nxt;
  word_t             base;
  logic [WordBits:0] base_sum;

  // seed fill order walks 21*k mod 55
  assign k_sum = {1'b0, k_r} + (IdxBits+1)'(SeedStride);
  assign k_nxt = (k_sum >= (IdxBits+1)'(TableWords)) ?
                 IdxBits'(k_sum - (IdxBits+1)'(TableWords)) : IdxBits'(k_sum);

  assign rot_nxt  = {rot_r[0], rot_r[WordBits-1:1]};
  assign next_nxt = sub31(sub31(prev_r, next_r), rot_nxt);

  // refresh partner word
  assign j_idx = (i_r < IdxBits'(ShortLag)) ? i_r + IdxBits'(LongLag)
                                            : i_r - IdxBits'(ShortLag);
  assign ra_a    = cmd.word_read ? pos_r - IdxBits'(1) : i_r;
  assign ref_val = sub31(rd_a_r, rd_b_r);

  always_comb begin
    mem_we = cmd.seed_start | cmd.seed_step | cmd.ref_write;
    mem_wa = i_r;
    mem_wd = ref_val;
    if (cmd.seed_start) begin
      mem_wa = IdxBits'(TableWords - 1);
      mem_wd = seed_r;
    end else if (cmd.seed_step) begin
      mem_wa = k_r - IdxBits'(1);
      mem_wd = next_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_a_r <= mem[ra_a];
    rd_b_r <= mem[j_idx];
  end

  // restoring remainder, one bit a cycle
  assign trial     = {rem_r, d_r[WordBits-1]};
  assign trial_ge  = trial >= {1'b0, m_r};
  assign trial_sub = trial - {1'b0, m_r};
  assign rem_nxt   = trial_ge ? trial_sub[WordBits-1:0] : trial[WordBits-1:0];

  // word is rejected when its multiple of m plus m passes 2^31
  assign base     = r_r - rem_r;
  assign base_sum = {1'b0, base} + {1'b0, m_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SeedReset;
    end else if (cfg_bus.valid) begin
      seed_r <= cfg_bus.seed_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seed_start) begin
      rot_r  <= seed_r;
      prev_r <= seed_r;
      next_r <= word_t'(1);
      k_r    <= IdxBits'(SeedStride);
    end else if (cmd.seed_step) begin
      rot_r  <= rot_nxt;
      prev_r <= next_r;
      next_r <= next_nxt;
      k_r    <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ref_start) begin
      i_r <= '0;
    end else if (cmd.ref_write) begin
      i_r <= i_r + IdxBits'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seed_start || cmd.word_load_ref) begin
      pos_r <= IdxBits'(TableWords - 1);
    end else if (cmd.word_read) begin
      pos_r <= pos_r - IdxBits'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      m_r <= in_modulus;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.word_load_mem) begin
      r_r   <= rd_a_r;
      d_r   <= rd_a_r;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.word_load_ref) begin
      r_r   <= ref_val;
      d_r   <= ref_val;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      d_r   <= {d_r[WordBits-2:0], 1'b0};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + CntBits'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value_r <= cmd.out_zero ? '0 : rem_r;
    end
  end

  assign cfg_bus.ready = 1'b1;
  assign out_bus.valid = out_valid_r;
  assign out_bus.value = out_value_r;

  assign st.seed_last = (k_nxt == '0);
  assign st.ref_last  = (i_r == IdxBits'(TableWords - 1));
  assign st.pos_zero  = (pos_r == '0);
  assign st.div_last  = (cnt_r == CntBits'(WordBits - 1));
  assign st.reject    = (base_sum > {1'b1, {WordBits{1'b0}}});
  assign st.out_free  = !out_valid_r || out_bus.ready;
  assign st.in_reseed = (in_opcode == OP_RESEED);
  assign st.in_small  = (in_modulus < word_t'(2));

endmodule

// ===== rtl/srg_ctrl.sv =====
// ----------------------------------------------------------------------------
// srg_ctrl
// Sequencer for seeding, table refresh passes, word fetch, remainder
// steps, rejection retry and result hand-off.
// ----------------------------------------------------------------------------
module srg_ctrl import srg_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SEEDI = 4'd1;
  localparam logic [3:0] S_SEED  = 4'd2;
  localparam logic [3:0] S_RRD   = 4'd3;
  localparam logic [3:0] S_RWR   = 4'd4;
  localparam logic [3:0] S_FETCH = 4'd5;
  localparam logic [3:0] S_FWAIT = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_CHECK = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  localparam int PassBits = $clog2(RefreshPasses);

  logic [3:0]          state_r;
  logic [3:0]          state_nxt;
  logic [PassBits-1:0] pass_r;
  logic [PassBits-1:0] pass_nxt;
  logic                draw_r;
  logic                draw_nxt;
  logic                small_r;
  logic                small_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    pass_nxt  = pass_r;
    draw_nxt  = draw_r;
    small_nxt = small_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (st.in_reseed) begin
            state_nxt = S_SEEDI;
          end else if (st.in_small) begin
            small_nxt = 1'b1;
            state_nxt = S_OUT;
          end else begin
            small_nxt = 1'b0;
            state_nxt = S_FETCH;
          end
        end
      end
      S_SEEDI: begin
        cmd.seed_start = 1'b1;
        state_nxt      = S_SEED;
      end
      S_SEED: begin
        cmd.seed_step = 1'b1;
        if (st.seed_last) begin
          cmd.ref_start = 1'b1;
          pass_nxt      = '0;
          draw_nxt      = 1'b0;
          state_nxt     = S_RRD;
        end
      end
      S_RRD: begin
        cmd.ref_read = 1'b1;
        state_nxt    = S_RWR;
      end
      S_RWR: begin
        cmd.ref_write = 1'b1;
        state_nxt     = S_RRD;
        if (st.ref_last) begin
          if (draw_r) begin
            cmd.word_load_ref = 1'b1;
            state_nxt         = S_DIV;
          end else if (pass_r == PassBits'(RefreshPasses - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.ref_start = 1'b1;
            pass_nxt      = pass_r + PassBits'(1);
          end
        end
      end
      S_FETCH: begin
        if (st.pos_zero) begin
          cmd.ref_start = 1'b1;
          draw_nxt      = 1'b1;
          state_nxt     = S_RRD;
        end else begin
          cmd.word_read = 1'b1;
          state_nxt     = S_FWAIT;
        end
      end
      S_FWAIT: begin
        cmd.word_load_mem = 1'b1;
        state_nxt         = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = st.reject ? S_FETCH : S_OUT;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_zero = small_r;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SEEDI;
      pass_r  <= '0;
      draw_r  <= 1'b0;
      small_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
      draw_r  <= draw_nxt;
      small_r <= small_nxt;
    end
  end

endmodule

// ===== rtl/subtractive_random_generator.sv =====
// draw: result word after word fetch, remainder and rejection check, one remainder bit per cycle
// a rejected word adds another fetch and remainder; every 55th word adds a table refresh
// (a read state and a write state per table word, through the memory's read and write ports)
// reseed: 55 fill writes and five refresh passes, no result word
// reset: the block seeds itself from the reset seed, request ready low
// ----------------------------------------------------------------------------
// subtractive_random_generator
// Subtractive lagged-Fibonacci generator, lags 55 and 24, with rejection
// sampling and a bit-serial remainder for bounded draws.
// ----------------------------------------------------------------------------
module subtractive_random_generator import srg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  srg_in_if.sink     in_bus,
  srg_out_if.source  out_bus,
  srg_cfg_if.sink    cfg_bus
);

  cmd_t  cmd;
  stat_t st;

  srg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .st       (st),
    .cmd      (cmd)
  );

  srg_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_opcode  (in_bus.opcode),
    .in_modulus (in_bus.modulus),
    .cfg_bus    (cfg_bus),
    .out_bus    (out_bus)
  );

endmodule
